FILE: src/tcgr_pkg.sv
package tcgr_pkg;

  // glyph scale default: each font bit becomes this many pixels and each
  // font row this many scan lines
  localparam int GLYPH_SCALE_DEF = 2;

  localparam int OFFSET_W  = 25;
  localparam int MASK_W    = 16;
  localparam int RGB_W     = 24;
  localparam int GLYPH_W   = 64;
  localparam int SIZE_W    = 9;
  localparam int PITCH_W   = 14;
  localparam int CURSOR_W  = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BG      = 3'd4;

  localparam logic [SIZE_W-1:0]  COLUMNS_RST = 9'd80;
  localparam logic [SIZE_W-1:0]  ROWS_RST    = 9'd25;
  localparam logic [PITCH_W-1:0] PITCH_RST   = 14'd1280;
  localparam logic [RGB_W-1:0]   FG_RST      = 24'h00FF00;
  localparam logic [RGB_W-1:0]   BG_RST      = 24'h000000;

  // commands and control characters
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_SET = 1'b1;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;

  // depth of the job queue between front and back
  localparam int Q_DEPTH = 2;

  // one cell to draw; a cleared cell carries an all-zero glyph
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [GLYPH_W-1:0]  glyph;
  } job_t;

endpackage

FILE: src/tcgr_front.sv
module tcgr_front #(
  parameter int GLYPH_SCALE = tcgr_pkg::GLYPH_SCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [7:0]                    char_code,
  input  logic [tcgr_pkg::GLYPH_W-1:0]  glyph_bits,
  input  logic [7:0]                    new_row,
  input  logic [7:0]                    new_col,
  input  logic [tcgr_pkg::SIZE_W-1:0]   text_columns,
  input  logic [tcgr_pkg::SIZE_W-1:0]   text_rows,
  input  logic [tcgr_pkg::PITCH_W-1:0]  pitch_words,
  input  logic                          q_full,
  output logic                          push,
  output tcgr_pkg::job_t                push_job
);

  localparam int CELL = 8 * GLYPH_SCALE;
  localparam int PX_W = 8 + $clog2(CELL);
  localparam int PROD_W = PX_W + tcgr_pkg::PITCH_W;

  logic [7:0] cursor_row, cursor_row_next;
  logic [7:0] cursor_col, cursor_col_next;

  // classified cell, waiting for its offset product and a queue slot
  logic                         cls_valid;
  logic [PX_W-1:0]              cls_row_px;
  logic [PX_W-1:0]              cls_col_px;
  logic [tcgr_pkg::GLYPH_W-1:0] cls_glyph;

  logic [8:0] cols_size, rows_size;
  logic [7:0] max_c, max_r;
  logic [8:0] row_inc, col_inc;
  logic [7:0] row_adv;
  logic       accept;
  logic       draw;
  logic       clear;
  logic [7:0] draw_row, draw_col;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] sum;

  // zero acts as one, anything above 256 as 256
  assign cols_size = (text_columns == 9'd0) ? 9'd1 :
                     (text_columns > 9'd256) ? 9'd256 : text_columns;
  assign rows_size = (text_rows == 9'd0) ? 9'd1 :
                     (text_rows > 9'd256) ? 9'd256 : text_rows;
  assign max_c = 8'(cols_size - 9'd1);
  assign max_r = 8'(rows_size - 9'd1);

  assign row_inc = {1'b0, cursor_row} + 9'd1;
  assign col_inc = {1'b0, cursor_col} + 9'd1;
  assign row_adv = (row_inc >= rows_size) ? 8'd0 : row_inc[7:0];

  assign in_stall = cls_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = cls_valid && !q_full;

  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    draw            = 1'b0;
    clear           = 1'b0;
    draw_row        = cursor_row;
    draw_col        = cursor_col;
    if (accept) begin
      if (cmd == tcgr_pkg::CMD_SET) begin
        cursor_row_next = (new_row > max_r) ? max_r : new_row;
        cursor_col_next = (new_col > max_c) ? max_c : new_col;
      end else begin
        unique case (char_code)
          tcgr_pkg::CHAR_BACKSPACE: begin
            if (cursor_col != 8'd0) begin
              cursor_col_next = cursor_col - 8'd1;
            end else if (cursor_row != 8'd0) begin
              cursor_row_next = cursor_row - 8'd1;
              cursor_col_next = max_c;
            end
            draw     = 1'b1;
            clear    = 1'b1;
            draw_row = cursor_row_next;
            draw_col = cursor_col_next;
          end
          tcgr_pkg::CHAR_NEWLINE: begin
            cursor_col_next = 8'd0;
            cursor_row_next = row_adv;
          end
          default: begin
            draw = 1'b1;
            if (col_inc >= cols_size) begin
              cursor_col_next = 8'd0;
              cursor_row_next = row_adv;
            end else begin
              cursor_col_next = col_inc[7:0];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= 8'd0;
      cursor_col <= 8'd0;
      cls_valid  <= 1'b0;
    end else begin
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      if (draw) begin
        cls_valid <= 1'b1;
      end else if (push) begin
        cls_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      cls_row_px <= PX_W'(draw_row) * PX_W'(CELL);
      cls_col_px <= PX_W'(draw_col) * PX_W'(CELL);
      cls_glyph  <= clear ? '0 : glyph_bits;
    end
  end

  // offset of the cell's top scan line, wraps at the offset width
  assign prod = PROD_W'(cls_row_px) * PROD_W'(pitch_words);
  assign sum  = prod + PROD_W'(cls_col_px);
  assign push_job.offset = sum[tcgr_pkg::OFFSET_W-1:0];
  assign push_job.glyph  = cls_glyph;

`ifndef SYNTHESIS
  // input held back only while a classified cell waits on a full queue
  a_stall_has_cell: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> cls_valid)
    else $error("front stalls with no pending cell");
`endif

endmodule

FILE: src/tcgr_queue.sv
module tcgr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcgr_pkg::job_t push_job,
  output logic           full,
  output logic           q_valid,
  output tcgr_pkg::job_t q_job,
  input  logic           pop
);

  localparam int DEPTH = tcgr_pkg::Q_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcgr_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("job queue underflow");
`endif

endmodule

FILE: src/tcgr_back.sv
module tcgr_back #(
  parameter int GLYPH_SCALE = tcgr_pkg::GLYPH_SCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tcgr_pkg::job_t                q_job,
  output logic                          q_pop,
  input  logic [tcgr_pkg::PITCH_W-1:0]  pitch_words,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcgr_pkg::OFFSET_W-1:0] line_offset,
  output logic [tcgr_pkg::MASK_W-1:0]   pixel_mask,
  output logic                          last
);

  localparam int CELL = 8 * GLYPH_SCALE;
  localparam int RW   = $clog2(CELL);
  localparam logic [RW-1:0] LAST_ROW = RW'(CELL - 1);
  localparam int REP_W = (GLYPH_SCALE > 1) ? $clog2(GLYPH_SCALE) : 1;
  localparam logic [REP_W-1:0] LAST_REP = REP_W'(GLYPH_SCALE - 1);

  logic                          active;
  logic [RW-1:0]                 row;
  logic [REP_W-1:0]              rep;
  logic [2:0]                    font_y;
  logic [tcgr_pkg::OFFSET_W-1:0] off;
  logic [tcgr_pkg::GLYPH_W-1:0]  glyph;

  logic                         emit;
  logic                         row_end;
  logic [7:0]                   font_bits;
  logic [tcgr_pkg::MASK_W-1:0]  row_mask;

  assign emit    = active && (!out_valid || !out_stall);
  assign row_end = emit && (row == LAST_ROW);
  assign q_pop   = q_valid && (!active || row_end);

  // each font row repeats GLYPH_SCALE times, each font bit widens likewise;
  // rep counts the repeats so the font row steps without a divide
  assign font_bits = glyph[{font_y, 3'b000} +: 8];

  always_comb begin
    row_mask = '0;
    for (int k = 0; k < tcgr_pkg::MASK_W; k++) begin
      if (k < CELL) begin
        row_mask[k] = font_bits[(k / GLYPH_SCALE) % 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      row       <= '0;
      rep       <= '0;
      font_y    <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
        row    <= '0;
        rep    <= '0;
        font_y <= 3'd0;
      end else if (row_end) begin
        active <= 1'b0;
        row    <= '0;
        rep    <= '0;
        font_y <= 3'd0;
      end else if (emit) begin
        row <= row + 1'b1;
        if (rep == LAST_REP) begin
          rep    <= '0;
          font_y <= font_y + 3'd1;
        end else begin
          rep <= rep + 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      off   <= q_job.offset;
      glyph <= q_job.glyph;
    end else if (emit) begin
      off <= off + tcgr_pkg::OFFSET_W'(pitch_words);
    end
    if (emit) begin
      line_offset <= off;
      pixel_mask  <= row_mask;
      last        <= (row == LAST_ROW);
    end
  end

`ifndef SYNTHESIS
  // an idle back end always restarts at the top scan line
  a_idle_row_zero: assert property (@(posedge clk) disable iff (rst)
    !active |-> (row == '0))
    else $error("row counter not cleared while idle");
  // a cell ends exactly on the beat flagged last
  a_last_ends_cell: assert property (@(posedge clk) disable iff (rst)
    row_end |=> (out_valid && last))
    else $error("final scan line not flagged");
`endif

endmodule

FILE: src/text_console_glyph_renderer.sv
// Path: a drawn character's first row beat passes the classify register, the job queue,
//   the back end's cell registers and the output register.
// Throughput: the back end emits one scan line per cycle while out_stall allows it; a drawn
//   character gives 8*GLYPH_SCALE scan lines (16 by default); newline and set-cursor draw nothing.
// Reset (rst, synchronous, active high): cursor to (0,0), registers to defaults,
//   queue and output empty.
module text_console_glyph_renderer #(
  parameter int GLYPH_SCALE = tcgr_pkg::GLYPH_SCALE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [7:0]                       char_code,
  input  logic [tcgr_pkg::GLYPH_W-1:0]     glyph_bits,
  input  logic [7:0]                       new_row,
  input  logic [7:0]                       new_col,
  // result channel, one beat per scaled scan line
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tcgr_pkg::OFFSET_W-1:0]    line_offset,
  output logic [tcgr_pkg::MASK_W-1:0]      pixel_mask,
  output logic [tcgr_pkg::RGB_W-1:0]       ink_color,
  output logic [tcgr_pkg::RGB_W-1:0]       paper_color,
  output logic                             last
);

  // Configuration registers; the user must change them only while the block is idle
  // (the block does not enforce it), so colors go to the result ports, stable under stall.
  logic [tcgr_pkg::SIZE_W-1:0]  text_columns;
  logic [tcgr_pkg::SIZE_W-1:0]  text_rows;
  logic [tcgr_pkg::PITCH_W-1:0] pitch_words;
  logic [tcgr_pkg::RGB_W-1:0]   fg_rgb;
  logic [tcgr_pkg::RGB_W-1:0]   bg_rgb;

  // front -> queue -> back
  logic           push;
  tcgr_pkg::job_t push_job;
  logic           q_full;
  logic           q_valid;
  tcgr_pkg::job_t q_job;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= tcgr_pkg::COLUMNS_RST;
      text_rows    <= tcgr_pkg::ROWS_RST;
      pitch_words  <= tcgr_pkg::PITCH_RST;
      fg_rgb       <= tcgr_pkg::FG_RST;
      bg_rgb       <= tcgr_pkg::BG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tcgr_pkg::REG_COLUMNS: text_columns <= cfg_data[tcgr_pkg::SIZE_W-1:0];
        tcgr_pkg::REG_ROWS:    text_rows    <= cfg_data[tcgr_pkg::SIZE_W-1:0];
        tcgr_pkg::REG_PITCH:   pitch_words  <= cfg_data[tcgr_pkg::PITCH_W-1:0];
        tcgr_pkg::REG_FG:      fg_rgb       <= cfg_data[tcgr_pkg::RGB_W-1:0];
        tcgr_pkg::REG_BG:      bg_rgb       <= cfg_data[tcgr_pkg::RGB_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign ink_color   = fg_rgb;
  assign paper_color = bg_rgb;

  // Front: owns the cursor, classifies each beat (set cursor, newline,
  // backspace, printable) and turns a cell to draw into a start offset.
  tcgr_front #(
    .GLYPH_SCALE (GLYPH_SCALE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .char_code    (char_code),
    .glyph_bits   (glyph_bits),
    .new_row      (new_row),
    .new_col      (new_col),
    .text_columns (text_columns),
    .text_rows    (text_rows),
    .pitch_words  (pitch_words),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  // Short queue so cursor commands keep flowing while cells are drawn.
  tcgr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (q_pop)
  );

  // Back: walks the scan lines of one cell, stepping the offset by the pitch,
  // and loads the next cell on the last line so cells run back to back.
  tcgr_back #(
    .GLYPH_SCALE (GLYPH_SCALE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .pitch_words (pitch_words),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_offset (line_offset),
    .pixel_mask  (pixel_mask),
    .last        (last)
  );

endmodule

FILE: sim/tb_text_console_glyph_renderer.sv
module tb_text_console_glyph_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  // cell geometry at the scale the block is built with
  localparam int SCALE = tcgr_pkg::GLYPH_SCALE_DEF;
  localparam int CELL  = 8 * SCALE;

  // one scan-line write as the block should emit it
  typedef struct {
    logic [tcgr_pkg::OFFSET_W-1:0] offset;
    logic [tcgr_pkg::MASK_W-1:0]   mask;
    logic [tcgr_pkg::RGB_W-1:0]    fg;
    logic [tcgr_pkg::RGB_W-1:0]    bg;
    logic                          last;
  } row_write_t;

  // Tracks the text cursor and the register file, turns each accepted
  // input beat into the row writes it should cause, and checks the
  // result beats against them in order.
  class glyph_row_board;
    row_write_t pending_rows[$];
    int errors;
    logic [tcgr_pkg::SIZE_W-1:0]   cols_reg;
    logic [tcgr_pkg::SIZE_W-1:0]   rows_reg;
    logic [tcgr_pkg::PITCH_W-1:0]  pitch_reg;
    logic [tcgr_pkg::RGB_W-1:0]    fg_reg;
    logic [tcgr_pkg::RGB_W-1:0]    bg_reg;
    logic [tcgr_pkg::CURSOR_W-1:0] cur_row;
    logic [tcgr_pkg::CURSOR_W-1:0] cur_col;

    function new();
      cols_reg  = tcgr_pkg::COLUMNS_RST;
      rows_reg  = tcgr_pkg::ROWS_RST;
      pitch_reg = tcgr_pkg::PITCH_RST;
      fg_reg    = tcgr_pkg::FG_RST;
      bg_reg    = tcgr_pkg::BG_RST;
      cur_row   = '0;
      cur_col   = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [tcgr_pkg::CFG_IDX_W-1:0] idx,
                          logic [tcgr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tcgr_pkg::REG_COLUMNS: cols_reg  = data[tcgr_pkg::SIZE_W-1:0];
        tcgr_pkg::REG_ROWS:    rows_reg  = data[tcgr_pkg::SIZE_W-1:0];
        tcgr_pkg::REG_PITCH:   pitch_reg = data[tcgr_pkg::PITCH_W-1:0];
        tcgr_pkg::REG_FG:      fg_reg    = data[tcgr_pkg::RGB_W-1:0];
        tcgr_pkg::REG_BG:      bg_reg    = data[tcgr_pkg::RGB_W-1:0];
        default: ;
      endcase
    endfunction

    // size registers: zero acts as one, past 256 acts as 256
    function int unsigned cells(logic [tcgr_pkg::SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return 32'(v);
    endfunction

    // "at or above" compare, so a cursor left past a shrunk screen wraps at once
    function void next_line();
      int unsigned r;
      r = cur_row + 32'd1;
      if (r >= cells(rows_reg)) r = 0;
      cur_row = tcgr_pkg::CURSOR_W'(r);
    endfunction

    function void draw_cell(logic [tcgr_pkg::GLYPH_W-1:0] glyph, bit blank);
      row_write_t w;
      logic [7:0] bits;
      longint unsigned off;
      int r;
      int k;
      for (r = 0; r < CELL; r++) begin
        bits = 8'(glyph >> ((8 * (r / SCALE)) & 63));
        w.mask = '0;
        if (!blank) begin
          for (k = 0; k < CELL && k < tcgr_pkg::MASK_W; k++)
            if (bits[(k / SCALE) & 7]) w.mask[k] = 1'b1;
        end
        off = 64'(cur_row);
        off = (off * CELL + r) * pitch_reg + cur_col * CELL;
        w.offset = off[tcgr_pkg::OFFSET_W-1:0];
        w.fg = fg_reg;
        w.bg = bg_reg;
        w.last = (r == CELL - 1);
        pending_rows.push_back(w);
      end
    endfunction

    function void note_input(logic c, logic [7:0] ch, logic [tcgr_pkg::GLYPH_W-1:0] glyph,
                             logic [7:0] nr, logic [7:0] nc);
      int unsigned lim_r;
      int unsigned lim_c;
      lim_r = cells(rows_reg) - 1;
      lim_c = cells(cols_reg) - 1;
      if (c == tcgr_pkg::CMD_SET) begin
        cur_row = (nr > lim_r) ? tcgr_pkg::CURSOR_W'(lim_r) : nr;
        cur_col = (nc > lim_c) ? tcgr_pkg::CURSOR_W'(lim_c) : nc;
      end else if (ch == tcgr_pkg::CHAR_BACKSPACE) begin
        if (cur_col > 0) begin
          cur_col = cur_col - 1'b1;
        end else if (cur_row > 0) begin
          cur_row = cur_row - 1'b1;
          cur_col = tcgr_pkg::CURSOR_W'(lim_c);
        end
        draw_cell('0, 1'b1);
      end else if (ch == tcgr_pkg::CHAR_NEWLINE) begin
        cur_col = '0;
        next_line();
      end else begin
        draw_cell(glyph, 1'b0);
        if (cur_col + 32'd1 >= cells(cols_reg)) begin
          cur_col = '0;
          next_line();
        end else begin
          cur_col = cur_col + 1'b1;
        end
      end
    endfunction

    function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
    endfunction

    function void check_row(logic [tcgr_pkg::OFFSET_W-1:0] offset,
                            logic [tcgr_pkg::MASK_W-1:0] mask,
                            logic [tcgr_pkg::RGB_W-1:0] fg,
                            logic [tcgr_pkg::RGB_W-1:0] bg, logic lst);
      row_write_t w;
      if (pending_rows.size() == 0) begin
        report("unexpected row write, line_offset", '0, 64'(offset));
        return;
      end
      w = pending_rows.pop_front();
      if (w.offset !== offset) report("line_offset", 64'(w.offset), 64'(offset));
      if (w.mask !== mask)     report("pixel_mask", 64'(w.mask), 64'(mask));
      if (w.fg !== fg)         report("ink_color", 64'(w.fg), 64'(fg));
      if (w.bg !== bg)         report("paper_color", 64'(w.bg), 64'(bg));
      if (w.last !== lst)      report("last", 64'(w.last), 64'(lst));
    endfunction

    function int pending_count();
      return pending_rows.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_we    = 1'b0;
  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic                            cmd       = tcgr_pkg::CMD_PUT;
  logic [7:0]                      char_code = '0;
  logic [tcgr_pkg::GLYPH_W-1:0]    glyph_bits = '0;
  logic [7:0]                      new_row   = '0;
  logic [7:0]                      new_col   = '0;

  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [tcgr_pkg::OFFSET_W-1:0]   line_offset;
  logic [tcgr_pkg::MASK_W-1:0]     pixel_mask;
  logic [tcgr_pkg::RGB_W-1:0]      ink_color;
  logic [tcgr_pkg::RGB_W-1:0]      paper_color;
  logic                            last;

  // long_hold: receiver holds off for a long stretch once
  // tail_quiet: no idling on either side for the final phase
  bit long_hold  = 1'b0;
  bit tail_quiet = 1'b0;

  glyph_row_board board = new();

  text_console_glyph_renderer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .char_code   (char_code),
    .glyph_bits  (glyph_bits),
    .new_row     (new_row),
    .new_col     (new_col),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_offset (line_offset),
    .pixel_mask  (pixel_mask),
    .ink_color   (ink_color),
    .paper_color (paper_color),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: every beat taken at a rising edge is checked against the
  // oldest expected row write.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_row(line_offset, pixel_mask, ink_color, paper_color, last);
  end

  // Receiver stall pattern, changed only at falling edges. The long hold is
  // counted here so the sender keeps offering beats while it lasts.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (150) @(negedge clk);
        out_stall = 1'b0;
        long_hold = 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Hard stop: well past the slowest legal run (every beat drawing a cell,
  // every row write stalled at the longest random hold, every input gap at its longest).
  initial begin
    #5_000_000;
    $display("** text_console_glyph_renderer: FAILED **");
    $finish;
  end

  // All driver tasks start and end at a falling edge.
  // One input beat. Valid stays high afterwards so back-to-back beats need
  // no drop; whoever pauses next lowers it.
  task automatic send_beat(logic b_cmd, logic [7:0] b_char,
                           logic [tcgr_pkg::GLYPH_W-1:0] b_glyph,
                           logic [7:0] b_row, logic [7:0] b_col);
    if (!tail_quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid   = 1'b1;
    cmd        = b_cmd;
    char_code  = b_char;
    glyph_bits = b_glyph;
    new_row    = b_row;
    new_col    = b_col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(b_cmd, b_char, b_glyph, b_row, b_col);
    @(negedge clk);
  endtask

  function automatic logic [tcgr_pkg::GLYPH_W-1:0] rand_glyph();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // cursor-set fields are don't-care on a put, and char/glyph on a set
  task automatic put_char(logic [7:0] ch, logic [tcgr_pkg::GLYPH_W-1:0] g);
    send_beat(tcgr_pkg::CMD_PUT, ch, g, 8'($urandom), 8'($urandom));
  endtask

  task automatic set_cursor(logic [7:0] r, logic [7:0] c);
    send_beat(tcgr_pkg::CMD_SET, 8'($urandom), rand_glyph(), r, c);
  endtask

  // Wait out every expected write, then wait on with the input idle so a trailing
  // newline or cursor set has cleared the front end before a register write.
  task automatic settle();
    in_valid = 1'b0;
    while (board.pending_count() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [tcgr_pkg::CFG_IDX_W-1:0] idx,
                           logic [tcgr_pkg::CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // size picks lean on the extremes and on tiny screens, where wraps are common
  function automatic logic [tcgr_pkg::CFG_DATA_W-1:0] pick_size();
    int unsigned v;
    case ($urandom_range(0, 6))
      0: v = 1;
      1: v = 256;
      2: v = 0;
      3: v = $urandom_range(257, 511);
      4: v = $urandom_range(1, 256);
      default: v = $urandom_range(2, 12);
    endcase
    return tcgr_pkg::CFG_DATA_W'(v);
  endfunction

  function automatic logic [tcgr_pkg::CFG_DATA_W-1:0] pick_pitch();
    int unsigned v;
    case ($urandom_range(0, 4))
      0: v = 16;
      1: v = 8192;
      2: v = 16383;
      default: v = $urandom_range(16, 8192);
    endcase
    return tcgr_pkg::CFG_DATA_W'(v);
  endfunction

  function automatic logic [tcgr_pkg::CFG_DATA_W-1:0] pick_rgb();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly drawn characters, with backspaces, newlines and cursor moves
  // mixed in; cursor moves often land past the edge to hit the clamp.
  task automatic random_beat();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 68)
      put_char(8'($urandom), rand_glyph());
    else if (sel < 80)
      put_char(tcgr_pkg::CHAR_BACKSPACE, rand_glyph());
    else if (sel < 88)
      put_char(tcgr_pkg::CHAR_NEWLINE, rand_glyph());
    else if (sel < 94)
      set_cursor(8'($urandom), 8'($urandom));
    else
      set_cursor(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
  endtask

  initial begin
    int ph;
    int i;

    // synchronous reset, held from time zero and released at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed: default 80x25 screen ---
    put_char(8'h41, '1);                        // full mask
    put_char(8'h00, '0);                        // empty mask, lowest code
    put_char(8'hFF, 64'h55AA_0FF0_8001_7E3C);   // highest code, mixed rows
    put_char(tcgr_pkg::CHAR_BACKSPACE, rand_glyph());  // back one column, cleared
    put_char(tcgr_pkg::CHAR_NEWLINE, rand_glyph());    // no writes
    put_char(tcgr_pkg::CHAR_BACKSPACE, rand_glyph());  // column 0: up to last column
    put_char(8'h5A, 64'hF0F0_F0F0_0F0F_0F0F);   // last column: wraps to next line
    send_beat(tcgr_pkg::CMD_SET, tcgr_pkg::CHAR_BACKSPACE, '1, 8'd0, 8'd0);  // ignores char
    put_char(tcgr_pkg::CHAR_BACKSPACE, rand_glyph());  // at the origin: cursor stays
    set_cursor(8'd255, 8'd255);                 // clamps to bottom-right
    put_char(8'h7E, rand_glyph());              // wraps column and row
    set_cursor(8'd24, 8'd5);
    put_char(tcgr_pkg::CHAR_NEWLINE, rand_glyph());    // newline on last row wraps

    // one-cell screen: every character wraps both ways
    settle();
    write_reg(tcgr_pkg::REG_COLUMNS, 24'd1);
    write_reg(tcgr_pkg::REG_ROWS, 24'd1);
    put_char(8'h31, rand_glyph());
    put_char(8'h32, rand_glyph());
    put_char(tcgr_pkg::CHAR_BACKSPACE, rand_glyph());

    // zero size acts as one
    settle();
    write_reg(tcgr_pkg::REG_COLUMNS, 24'd0);
    write_reg(tcgr_pkg::REG_ROWS, 24'd0);
    set_cursor(8'd3, 8'd3);
    put_char(8'h33, rand_glyph());

    // oversize acts as 256; widest pitch overflows the offset
    settle();
    write_reg(tcgr_pkg::REG_COLUMNS, 24'd511);
    write_reg(tcgr_pkg::REG_ROWS, 24'd300);
    write_reg(tcgr_pkg::REG_PITCH, 24'd16383);
    set_cursor(8'd255, 8'd255);
    put_char(8'h34, '1);
    set_cursor(8'd200, 8'd250);

    // shrink under the cursor: drawn in place, then wraps to the origin
    settle();
    write_reg(tcgr_pkg::REG_COLUMNS, 24'd10);
    write_reg(tcgr_pkg::REG_ROWS, 24'd5);
    write_reg(tcgr_pkg::REG_FG, 24'hFFFFFF);
    write_reg(tcgr_pkg::REG_BG, 24'hFFFFFF);
    put_char(8'h35, rand_glyph());
    set_cursor(8'd4, 8'd9);
    put_char(8'h36, rand_glyph());

    // --- random phases, fresh register settings each time ---
    for (ph = 0; ph < 6; ph++) begin
      settle();
      write_reg(tcgr_pkg::REG_COLUMNS, pick_size());
      write_reg(tcgr_pkg::REG_ROWS, pick_size());
      write_reg(tcgr_pkg::REG_PITCH, pick_pitch());
      write_reg(tcgr_pkg::REG_FG, pick_rgb());
      write_reg(tcgr_pkg::REG_BG, pick_rgb());
      if (ph == 2) long_hold = 1'b1;    // fill the block while results back up
      if (ph == 5) tail_quiet = 1'b1;   // full rate to the end
      for (i = 0; i < 60; i++) random_beat();
    end

    settle();
    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.pending_count() == 0)
      $display("** text_console_glyph_renderer: PASSED **");
    else
      $display("** text_console_glyph_renderer: FAILED **");
    $finish;
  end

endmodule
